// File: rtl/lrt_pkg.sv
// lrt_pkg: shared sizes, request codes, state type and link-memory port struct
// for the lru replacement tracker. No dependencies.

package lrt_pkg;

  localparam int FRAMES = 256;
  localparam int KEY_W  = $clog2(FRAMES);
  localparam int CNT_W  = KEY_W + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_VICTIM = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_PUSH,
    ST_RESP
  } state_t;

  // one link memory: a write port and a read address
  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [KEY_W-1:0] raddr;
  } link_port_t;

endpackage

// File: rtl/lrt_ram.sv
// lrt_ram: generic single-write, single-read ram with registered read data.
// No dependencies.

module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lrt_ctrl.sv
// lrt_ctrl: request sequencer, head/tail/count registers, present bits and
// the result register. Drives the prev/next link rams. Depends on lrt_pkg.

module lrt_ctrl import lrt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [KEY_W-1:0] in_frame_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic [KEY_W-1:0] out_victim_key,
  output logic [CNT_W-1:0] out_tracked_count,
  output link_port_t       prev_port,
  output link_port_t       next_port,
  input  logic [KEY_W-1:0] prev_rdata,
  input  logic [KEY_W-1:0] next_rdata
);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              hit_r, hit_nxt;
  logic [KEY_W-1:0]  head_r, head_nxt;
  logic [KEY_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FRAMES-1:0] present_r, present_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [KEY_W-1:0]  out_victim_r, out_victim_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic             accept;
  logic             out_free;
  req_t             in_req;
  logic [KEY_W-1:0] rd_key;
  logic             in_hit;

  assign in_req = req_t'(in_req_type);

  // outputs and handshake
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    accept   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    // victim reads the tail links, the others the named frame
    rd_key   = (in_req == REQ_VICTIM) ? tail_r : in_frame_key;
    case (in_req)
      REQ_INSERT, REQ_ERASE: in_hit = present_r[in_frame_key];
      REQ_VICTIM:            in_hit = (count_r != '0);
      default:               in_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_hit) begin
            state_nxt = ST_UNLINK;
          end else if (in_req == REQ_INSERT) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_UNLINK: state_nxt = (req_r == REQ_INSERT) ? ST_PUSH : ST_RESP;
      ST_PUSH:   state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and link memory writes
  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    present_nxt    = present_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_victim_nxt = out_victim_r;
    out_count_nxt  = out_count_r;

    prev_port       = '0;
    next_port       = '0;
    prev_port.raddr = rd_key;
    next_port.raddr = rd_key;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req;
          key_nxt = rd_key;
          hit_nxt = in_hit;
        end
      end
      ST_UNLINK: begin
        if (key_r == head_r) begin
          head_nxt = next_rdata;
        end else begin
          next_port.we    = 1'b1;
          next_port.waddr = prev_rdata;
          next_port.wdata = next_rdata;
        end
        if (key_r == tail_r) begin
          tail_nxt = prev_rdata;
        end else begin
          prev_port.we    = 1'b1;
          prev_port.waddr = next_rdata;
          prev_port.wdata = prev_rdata;
        end
        present_nxt[key_r] = 1'b0;
        count_nxt          = count_r - CNT_W'(1);
      end
      ST_PUSH: begin
        prev_port.we    = 1'b1;
        next_port.we    = 1'b1;
        next_port.waddr = key_r;
        if (count_r == '0) begin
          tail_nxt        = key_r;
          prev_port.waddr = key_r;
          prev_port.wdata = key_r;
          next_port.wdata = key_r;
        end else begin
          // a head's own prev link only reaches the tail once the list is empty
          prev_port.waddr = head_r;
          prev_port.wdata = key_r;
          next_port.wdata = head_r;
        end
        head_nxt           = key_r;
        present_nxt[key_r] = 1'b1;
        count_nxt          = count_r + CNT_W'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = hit_r;
          out_victim_nxt = (req_r == REQ_VICTIM && hit_r) ? key_r : '0;
          out_count_nxt  = count_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    hit_r        <= hit_nxt;
    out_hit_r    <= out_hit_nxt;
    out_victim_r <= out_victim_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_victim_key    = out_victim_r;
  assign out_tracked_count = out_count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAMES))
    else $error("tracked count above frame count");

  a_empty_no_present: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (present_r == '0))
    else $error("present bit set with empty list");

  a_unlink_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNLINK) |-> present_r[key_r])
    else $error("unlinking a frame that is not tracked");

  a_push_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> !present_r[key_r])
    else $error("pushing a frame that is already tracked");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("accepted request did not start");

endmodule

// File: rtl/lru_replacement_tracker.sv
// lru_replacement_tracker: top level; sequencer plus prev and next link rams.
// Depends on lrt_pkg, lrt_ram and lrt_ctrl.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_req_type, in_frame_key
//   out_     output     out_valid/out_stall out_hit, out_victim_key,
//                                          out_tracked_count
//
// One request at a time: a miss that only reports goes straight to the result;
// a new insert takes the push step, an erase or victim hit the unlink step, and
// a tracked frame's insert both, unlink then push; ram reads are registered.
// Reset (synchronous, active low) clears the present bits and head/tail/count
// at once; the link rams need no clearing.
// A stalled result holds in the output register; the next request is taken
// while it waits, and a finished request waits for the register to free.

module lru_replacement_tracker import lrt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [KEY_W-1:0] in_frame_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic [KEY_W-1:0] out_victim_key,
  output logic [CNT_W-1:0] out_tracked_count
);

  link_port_t       prev_port;
  link_port_t       next_port;
  logic [KEY_W-1:0] prev_rdata;
  logic [KEY_W-1:0] next_rdata;

  lrt_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_frame_key      (in_frame_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_victim_key    (out_victim_key),
    .out_tracked_count (out_tracked_count),
    .prev_port         (prev_port),
    .next_port         (next_port),
    .prev_rdata        (prev_rdata),
    .next_rdata        (next_rdata)
  );

  lrt_ram #(.WIDTH(KEY_W), .DEPTH(FRAMES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_port.we),
    .waddr (prev_port.waddr),
    .wdata (prev_port.wdata),
    .raddr (prev_port.raddr),
    .rdata (prev_rdata)
  );

  lrt_ram #(.WIDTH(KEY_W), .DEPTH(FRAMES)) u_next_ram (
    .clk   (clk),
    .we    (next_port.we),
    .waddr (next_port.waddr),
    .wdata (next_port.wdata),
    .raddr (next_port.raddr),
    .rdata (next_rdata)
  );

endmodule

// File: tb/sv/lru_replacement_tracker_test.sv
// lru_replacement_tracker_test: self-checking bench for the lru replacement tracker.
// Predicts each reply from a queue kept in recency order and checks every field.
// Depends on lrt_pkg and the lru_replacement_tracker rtl.
`timescale 1ns / 1ps

module lru_replacement_tracker_test;
  import lrt_pkg::*;

  typedef struct packed {
    req_t             req;
    logic [KEY_W-1:0] key;
  } lru_req_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] victim;
    logic [CNT_W-1:0] count;
  } lru_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_req_type = '0;
  logic [KEY_W-1:0] in_frame_key = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_hit;
  logic [KEY_W-1:0] out_victim_key;
  logic [CNT_W-1:0] out_tracked_count;

  lru_replacement_tracker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_frame_key     (in_frame_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_victim_key   (out_victim_key),
    .out_tracked_count(out_tracked_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // front is the most recently used frame, back the next victim
  logic [KEY_W-1:0] lru_order[$];
  logic             tracked[FRAMES];

  lru_req_t   queued_requests[$];
  lru_reply_t pending_replies[$];
  lru_req_t   driven_req;
  int         accepted_count = 0;
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  function automatic void drop_frame(logic [KEY_W-1:0] key);
    for (int i = 0; i < lru_order.size(); i++) begin
      if (lru_order[i] == key) begin
        lru_order.delete(i);
        break;
      end
    end
    tracked[key] = 1'b0;
  endfunction

  function automatic lru_reply_t lru_update(lru_req_t r);
    lru_reply_t rep;
    rep = '0;
    case (r.req)
      REQ_INSERT: begin
        if (tracked[r.key]) begin
          rep.hit = 1'b1;
          drop_frame(r.key);
        end
        lru_order.push_front(r.key);
        tracked[r.key] = 1'b1;
      end
      REQ_VICTIM: begin
        if (lru_order.size() != 0) begin
          rep.hit = 1'b1;
          rep.victim = lru_order[lru_order.size() - 1];
          lru_order.delete(lru_order.size() - 1);
          tracked[rep.victim] = 1'b0;
        end
      end
      REQ_ERASE: begin
        if (tracked[r.key]) begin
          rep.hit = 1'b1;
          drop_frame(r.key);
        end
      end
      default: ;
    endcase
    rep.count = CNT_W'(lru_order.size());
    return rep;
  endfunction

  function automatic lru_req_t random_req();
    lru_req_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) r.req = REQ_INSERT;
    else if (pick < 68) r.req = REQ_VICTIM;
    else if (pick < 93) r.req = REQ_ERASE;
    else r.req = REQ_NONE;
    // a narrow key pool keeps touches and erases hitting
    if ($urandom_range(0, 1) != 0) r.key = KEY_W'($urandom_range(0, 23));
    else r.key = KEY_W'($urandom_range(0, FRAMES - 1));
    return r;
  endfunction

  task automatic queue_req(req_t req, int key);
    lru_req_t r;
    r.req = req;
    r.key = KEY_W'(key);
    queued_requests.push_back(r);
  endtask

  // sampled mid-cycle so the driver's and monitor's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || pending_replies.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_replies.push_back(lru_update(driven_req));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= driven_req.req;
          in_frame_key <= driven_req.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off to fill the block up
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && accepted_count >= 300) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    lru_reply_t exp_rep;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: hit %0d victim %0d count %0d",
               out_hit, out_victim_key, out_tracked_count);
        error_count++;
      end else begin
        exp_rep = pending_replies.pop_front();
        if (out_hit !== exp_rep.hit) begin
          $error("hit: expected %0d, got %0d", exp_rep.hit, out_hit);
          error_count++;
        end
        if (out_victim_key !== exp_rep.victim) begin
          $error("victim_key: expected %0d, got %0d", exp_rep.victim, out_victim_key);
          error_count++;
        end
        if (out_tracked_count !== exp_rep.count) begin
          $error("tracked_count: expected %0d, got %0d", exp_rep.count, out_tracked_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("lru_replacement_tracker verification failed");
    $finish;
  end

  initial begin
    int fill[FRAMES];
    int j;
    int tmp;

    foreach (tracked[i]) tracked[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: sender idles a little, receiver stalls a lot
    send_idle_pct = 23;
    recv_stall_pct = 63;
    queue_req(REQ_VICTIM, 0);   // victim on empty list
    queue_req(REQ_ERASE, 7);    // erase of untracked frame
    queue_req(REQ_NONE, 255);   // unused request type
    queue_req(REQ_INSERT, 0);
    queue_req(REQ_INSERT, 255);
    queue_req(REQ_INSERT, 0);   // touch the tail
    queue_req(REQ_INSERT, 128);
    queue_req(REQ_INSERT, 255); // touch the tail
    queue_req(REQ_ERASE, 0);    // erase the tail
    queue_req(REQ_NONE, 0);
    queue_req(REQ_VICTIM, 170);
    queue_req(REQ_VICTIM, 85);
    queue_req(REQ_VICTIM, 0);   // empty again
    queue_req(REQ_INSERT, 85);
    queue_req(REQ_INSERT, 170);
    queue_req(REQ_INSERT, 1);
    queue_req(REQ_INSERT, 1);   // touch the head
    queue_req(REQ_INSERT, 85);  // touch the tail
    queue_req(REQ_ERASE, 85);   // erase the head
    queue_req(REQ_ERASE, 170);  // erase the tail
    queue_req(REQ_VICTIM, 255); // last frame out
    queue_req(REQ_ERASE, 170);
    repeat (600) queued_requests.push_back(random_req());
    wait_drained();

    // phase 1: roles swapped; fill every frame, touch, then drain it all
    send_idle_pct = 63;
    recv_stall_pct = 23;
    repeat (lru_order.size() + 1) queue_req(REQ_VICTIM, 0);
    for (int i = 0; i < FRAMES; i++) fill[i] = i;
    for (int i = FRAMES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill[i];
      fill[i] = fill[j];
      fill[j] = tmp;
    end
    for (int i = 0; i < FRAMES; i++) queue_req(REQ_INSERT, fill[i]);
    repeat (40) queue_req(REQ_INSERT, $urandom_range(0, FRAMES - 1));
    queue_req(REQ_VICTIM, 0);
    queue_req(REQ_ERASE, $urandom_range(0, FRAMES - 1));
    queue_req(REQ_INSERT, fill[0]);
    queue_req(REQ_INSERT, fill[1]);
    repeat (FRAMES + 1) queue_req(REQ_VICTIM, $urandom_range(0, FRAMES - 1));
    repeat (150) queued_requests.push_back(random_req());
    wait_drained();

    // phase 2: back to back
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (500) queued_requests.push_back(random_req());
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("lru_replacement_tracker verification clean");
    end else begin
      $display("lru_replacement_tracker verification failed");
    end
    $finish;
  end

endmodule
